>>> rtl/fsbf_pkg.sv
// Shared constants, types and helper functions for the signed BCD formatter.
`timescale 1ns / 1ps

package fsbf_pkg;

  localparam int RAW_W       = 32;
  localparam int DEC_W       = 3;
  localparam int SPOS_W      = 5;
  localparam int BYTES_W     = 3;
  localparam int POW_W       = 14;
  localparam int PROD_W      = RAW_W + POW_W;
  localparam int DIGITS      = 8;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int BITS_PER_ST = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DEC_W-1:0]   DEC_MAX   = 3'd4;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 3'd4;

  typedef struct packed {
    logic [BCD_W-1:0]   mask;
    logic               neg;
    logic [SPOS_W-1:0]  spos;
    logic [BYTES_W-1:0] bytes;
  } side_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] dec);
    logic [POW_W-1:0] p;
    unique case (dec)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [BCD_W-1:0] keep_mask(input logic [BYTES_W-1:0] bytes);
    logic [BCD_W-1:0] k;
    priority if (bytes >= 3'd4) begin
      k = 32'hFFFF_FFFF;
    end else if (bytes == 3'd3) begin
      k = 32'h00FF_FFFF;
    end else if (bytes == 3'd2) begin
      k = 32'h0000_FFFF;
    end else if (bytes == 3'd1) begin
      k = 32'h0000_00FF;
    end else begin
      k = 32'h0000_0000;
    end
    return k;
  endfunction

endpackage

>>> rtl/fixed_to_signed_bcd_formatter.sv
// Top level: pipelined fixed-point to signed packed BCD formatter.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | raw_value, decimals, digit_mask,
//          |           |                       | sign_position, signed_mode, byte_count
//  out_    | output    | out_valid / out_stall | bcd_word, bytes_used
//
// One beat per cycle sustained while out_stall stays low. Stages, in order:
// negate, 32x14 multiply, round, one double-dabble stage per 8 quotient bits,
// output register.
// Each stage holds its beat while the next one is full and stalled; bubbles collapse.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps

module fixed_to_signed_bcd_formatter
  import fsbf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RAW_W-1:0]   in_raw_value,
  input  logic [DEC_W-1:0]   in_decimals,
  input  logic [BCD_W-1:0]   in_digit_mask,
  input  logic [SPOS_W-1:0]  in_sign_position,
  input  logic               in_signed_mode,
  input  logic [BYTES_W-1:0] in_byte_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BCD_W-1:0]   out_bcd_word,
  output logic [BYTES_W-1:0] out_bytes_used
);

  localparam int Q_W    = PROD_W - FRAC_BITS;
  localparam int ND     = (Q_W + BITS_PER_ST - 1) / BITS_PER_ST;
  localparam int QP_W   = ND * BITS_PER_ST;
  localparam int ST_NEG = 0;
  localparam int ST_MUL = 1;
  localparam int ST_RND = 2;
  localparam int ST_DD0 = 3;
  localparam int NMID   = ST_DD0 + ND;
  localparam int NSTG   = NMID + 1;
  localparam int ST_OUT = NSTG - 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'((64'd1 << FRAC_BITS) >> 1);

  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  vld_in;
  logic [NSTG:0]    rdy;

  side_t            side_r [NMID];
  side_t            side_nxt;
  logic [RAW_W-1:0] mag_r;
  logic [RAW_W-1:0] mag_nxt;
  logic [DEC_W-1:0] dec_r;
  logic [DEC_W-1:0] dec_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] sum_w;
  logic [QP_W-1:0]  qp_r;
  logic [QP_W-1:0]  qp_nxt;
  logic [BCD_W-1:0] bcd_r [ND];
  logic [QP_W-1:0]  qd_r [ND];
  logic [BCD_W-1:0] out_bcd_word_r;
  logic [BCD_W-1:0] out_bcd_word_nxt;
  logic [BYTES_W-1:0] out_bytes_used_r;
  logic [BCD_W-1:0] sign_word;
  side_t            side_last;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vld_in   = {vld_r[NSTG-2:0], in_valid};
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_in[i];
        end
      end
    end
  end

  always_comb begin
    side_nxt.mask  = in_digit_mask;
    side_nxt.neg   = in_signed_mode && in_raw_value[RAW_W-1];
    side_nxt.spos  = in_sign_position;
    side_nxt.bytes = (in_byte_count > BYTES_MAX) ? BYTES_MAX : in_byte_count;
    mag_nxt        = side_nxt.neg ? (~in_raw_value + 32'd1) : in_raw_value;
    dec_nxt        = (in_decimals > DEC_MAX) ? DEC_MAX : in_decimals;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_NEG]) begin
      side_r[ST_NEG] <= side_nxt;
      mag_r          <= mag_nxt;
      dec_r          <= dec_nxt;
    end
    for (int i = 1; i < NMID; i++) begin
      if (rdy[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign prod_nxt = PROD_W'(mag_r) * PROD_W'(pow10(dec_r));

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      prod_r <= prod_nxt;
    end
  end

  assign sum_w  = prod_r + HALF;
  assign qp_nxt = QP_W'(sum_w[PROD_W-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rdy[ST_RND]) begin
      qp_r <= qp_nxt;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_dd
    localparam int TOP = QP_W - 1 - k * BITS_PER_ST;
    logic [BCD_W-1:0]       bcd_in;
    logic [QP_W-1:0]        q_in;
    logic [BITS_PER_ST-1:0] slice;
    logic [BCD_W-1:0]       bcd_nxt;

    if (k == 0) begin : g_first
      assign bcd_in = '0;
      assign q_in   = qp_r;
    end else begin : g_rest
      assign bcd_in = bcd_r[k-1];
      assign q_in   = qd_r[k-1];
    end

    assign slice = q_in[TOP -: BITS_PER_ST];

    always_comb begin
      bcd_nxt = bcd_in;
      for (int j = BITS_PER_ST - 1; j >= 0; j--) begin
        bcd_nxt = dd_step(bcd_nxt, slice[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_DD0+k]) begin
        bcd_r[k] <= bcd_nxt;
        qd_r[k]  <= q_in;
      end
    end
  end

  assign side_last        = side_r[NMID-1];
  assign sign_word        = side_last.neg ? (32'd1 << side_last.spos) : '0;
  assign out_bcd_word_nxt = ((bcd_r[ND-1] & side_last.mask) | sign_word)
                            & keep_mask(side_last.bytes);

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_bcd_word_r   <= out_bcd_word_nxt;
      out_bytes_used_r <= side_last.bytes;
    end
  end

  assign out_valid      = vld_r[ST_OUT];
  assign out_bcd_word   = out_bcd_word_r;
  assign out_bytes_used = out_bytes_used_r;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[ST_NEG])
    else $error("accepted beat did not enter the first stage");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NMID-1] |-> bcd_ok(bcd_r[ND-1]))
    else $error("double-dabble produced a digit above nine");

  a_bytes_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes_used <= BYTES_MAX))
    else $error("byte count not clamped");

  a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_bytes_used == 3'd0)) |-> (out_bcd_word == '0))
    else $error("word not cleared for zero byte count");
`endif

endmodule

>>> tb/sv/fixed_to_signed_bcd_formatter_tb.sv
// Self-checking testbench for the fixed-point to signed packed BCD formatter.
`timescale 1ns / 1ps

module fixed_to_signed_bcd_formatter_tb;
  import fsbf_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam logic [63:0] HALF = (64'd1 << FRAC) >> 1;
  localparam int RANDOM_BEATS = 1900;
  localparam int PRESSURE_AT  = 700;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic KNOWN      = 1'b1;
  localparam logic PREDICTED  = 1'b0;
  localparam int IDLE_NONE    = 0;
  localparam int IDLE_MIXED   = 1;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [DEC_W-1:0]   dec;
    logic [BCD_W-1:0]   mask;
    logic [SPOS_W-1:0]  spos;
    logic               sgn;
    logic [BYTES_W-1:0] nbytes;
    logic               known;
    logic [BCD_W-1:0]   exp_word;
    logic [BYTES_W-1:0] exp_used;
  } beat_t;

  typedef struct packed {
    logic [BCD_W-1:0]   word;
    logic [BYTES_W-1:0] used;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [RAW_W-1:0]   in_raw_value;
  logic [DEC_W-1:0]   in_decimals;
  logic [BCD_W-1:0]   in_digit_mask;
  logic [SPOS_W-1:0]  in_sign_position;
  logic               in_signed_mode;
  logic [BYTES_W-1:0] in_byte_count;
  logic               out_valid;
  logic               out_stall;
  logic [BCD_W-1:0]   out_bcd_word;
  logic [BYTES_W-1:0] out_bytes_used;

  reading_t bcd_pending[$];
  int       failures = 0;
  int       cycle_count = 0;
  bit       hold_request = 1'b0;

  beat_t directed_beats [0:24] = '{
    '{32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0000_0000, 3'd4},
    '{32'h0001_0000, 3'd0, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0000_0001, 3'd4},
    '{32'h0001_0000, 3'd4, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0001_0000, 3'd4},
    '{32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h5536_0000, 3'd4},
    '{32'h8000_0000, 3'd0, 32'hFFFF_FFFF, 5'd31, 1'b1, 3'd4, KNOWN, 32'h8003_2768, 3'd4},
    '{32'h8000_0000, 3'd0, 32'hFFFF_FFFF, 5'd31, 1'b0, 3'd4, KNOWN, 32'h0003_2768, 3'd4},
    '{32'hFFFF_0000, 3'd2, 32'h0000_FFFF, 5'd15, 1'b1, 3'd2, KNOWN, 32'h0000_8100, 3'd2},
    '{32'hFFFF_0000, 3'd0, 32'hFFFF_FFFF, 5'd31, 1'b1, 3'd1, KNOWN, 32'h0000_0001, 3'd1},
    '{32'h1234_5678, 3'd1, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd0, KNOWN, 32'h0000_0000, 3'd0},
    '{32'h0001_0000, 3'd0, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd7, KNOWN, 32'h0000_0001, 3'd4},
    '{32'h0001_0000, 3'd7, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0001_0000, 3'd4},
    '{32'h0000_8000, 3'd0, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0000_0001, 3'd4},
    '{32'h0000_7FFF, 3'd0, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0000_0000, 3'd4},
    '{32'h0001_0000, 3'd4, 32'h0000_0000, 5'd0,  1'b0, 3'd4, KNOWN, 32'h0000_0000, 3'd4},
    '{32'hFFFF_0000, 3'd0, 32'h0000_0000, 5'd0,  1'b1, 3'd4, KNOWN, 32'h0000_0001, 3'd4},
    '{32'h7FFF_FFFF, 3'd4, 32'hFFFF_FFFF, 5'd31, 1'b1, 3'd4, PREDICTED, 32'h0, 3'd0},
    '{32'hFFFF_FFFF, 3'd4, 32'h0F0F_0F0F, 5'd7,  1'b1, 3'd3, PREDICTED, 32'h0, 3'd0},
    '{32'hDEAD_BEEF, 3'd3, 32'hFFFF_FFFF, 5'd23, 1'b1, 3'd3, PREDICTED, 32'h0, 3'd0},
    '{32'h0123_ABCD, 3'd5, 32'hF0F0_F0F0, 5'd3,  1'b0, 3'd2, PREDICTED, 32'h0, 3'd0},
    '{32'hA5A5_5A5A, 3'd6, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd5, PREDICTED, 32'h0, 3'd0},
    '{32'h5A5A_A5A5, 3'd1, 32'hFFFF_FFFF, 5'd12, 1'b1, 3'd6, PREDICTED, 32'h0, 3'd0},
    '{32'hC000_0000, 3'd2, 32'hFFFF_FFFF, 5'd30, 1'b1, 3'd4, PREDICTED, 32'h0, 3'd0},
    '{32'h3FFF_FFFF, 3'd3, 32'h0FFF_FFFF, 5'd0,  1'b0, 3'd4, PREDICTED, 32'h0, 3'd0},
    '{32'h0000_0001, 3'd4, 32'hFFFF_FFFF, 5'd0,  1'b0, 3'd4, PREDICTED, 32'h0, 3'd0},
    '{32'hFFFE_8000, 3'd1, 32'hFFFF_FFFF, 5'd16, 1'b1, 3'd3, PREDICTED, 32'h0, 3'd0}
  };

  fixed_to_signed_bcd_formatter #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_value     (in_raw_value),
    .in_decimals      (in_decimals),
    .in_digit_mask    (in_digit_mask),
    .in_sign_position (in_sign_position),
    .in_signed_mode   (in_signed_mode),
    .in_byte_count    (in_byte_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bcd_word     (out_bcd_word),
    .out_bytes_used   (out_bytes_used)
  );

  always #5 clk = ~clk;

  function automatic reading_t format_reading(input beat_t b);
    reading_t           r;
    logic [RAW_W-1:0]   mag;
    logic [BCD_W-1:0]   sign_bit;
    logic [BCD_W-1:0]   digits;
    logic [BCD_W-1:0]   keep;
    logic [63:0]        scale;
    logic [63:0]        q;
    logic [DEC_W-1:0]   places;
    logic [BYTES_W-1:0] nb;
    places = (b.dec > DEC_MAX) ? DEC_MAX : b.dec;
    nb = (b.nbytes > BYTES_MAX) ? BYTES_MAX : b.nbytes;
    scale = 64'd1;
    for (int k = 0; k < int'(places); k++) begin
      scale = scale * 64'd10;
    end
    mag = b.raw;
    sign_bit = '0;
    if (b.sgn && b.raw[RAW_W-1]) begin
      mag = ~b.raw + 32'd1;
      sign_bit = 32'd1 << b.spos;
    end
    q = ({32'd0, mag} * scale + HALF) >> FRAC;
    for (int k = 0; k < DIGITS; k++) begin
      digits[4*k +: 4] = 4'(q % 64'd10);
      q = q / 64'd10;
    end
    if (nb >= BYTES_MAX) begin
      keep = '1;
    end else begin
      keep = (32'd1 << (8 * nb)) - 32'd1;
    end
    r.word = ((digits & b.mask) | sign_bit) & keep;
    r.used = nb;
    return r;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    case ($urandom_range(0, 3))
      0: b.raw = $urandom();
      1: b.raw = $urandom_range(0, 32'h00FF_FFFF);
      2: b.raw = -$urandom_range(0, 32'h00FF_FFFF);
      default: begin
        case ($urandom_range(0, 3))
          0: b.raw = 32'h0000_0000;
          1: b.raw = 32'hFFFF_FFFF;
          2: b.raw = 32'h8000_0000;
          default: b.raw = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    b.dec = DEC_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 7));
    b.mask = ($urandom_range(0, 99) < 70) ? 32'hFFFF_FFFF : $urandom();
    b.spos = SPOS_W'($urandom_range(0, 31));
    b.sgn = 1'($urandom_range(0, 1));
    b.nbytes = BYTES_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                      : $urandom_range(0, 7));
    b.known = PREDICTED;
    b.exp_word = '0;
    b.exp_used = '0;
    return b;
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  task automatic send_beat(input beat_t b);
    reading_t want;
    in_valid         <= 1'b1;
    in_raw_value     <= b.raw;
    in_decimals      <= b.dec;
    in_digit_mask    <= b.mask;
    in_sign_position <= b.spos;
    in_signed_mode   <= b.sgn;
    in_byte_count    <= b.nbytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.known) begin
      want.word = b.exp_word;
      want.used = b.exp_used;
    end else begin
      want = format_reading(b);
    end
    bcd_pending.push_back(want);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bcd_pending.size() == 0) begin
        $error("unexpected beat: bcd_word %h bytes_used %0d", out_bcd_word, out_bytes_used);
        failures++;
      end else begin
        want = bcd_pending.pop_front();
        if (out_bcd_word !== want.word) begin
          $error("bcd_word: expected %h, actual %h", want.word, out_bcd_word);
          failures++;
        end
        if (out_bytes_used !== want.used) begin
          $error("bytes_used: expected %0d, actual %0d", want.used, out_bytes_used);
          failures++;
        end
      end
    end
  end

  initial begin
    int  stall_left;
    int  phase_left;
    bit  rx_busy;
    bit  hold_taken;
    stall_left = 0;
    phase_left = 0;
    rx_busy = 1'b0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        rx_busy = $urandom_range(0, 2) != 0;
        phase_left = $urandom_range(50, 400);
      end else begin
        phase_left--;
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_busy && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int gap_mode;
    gap_mode = IDLE_MIXED;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_raw_value     <= '0;
    in_decimals      <= '0;
    in_digit_mask    <= '0;
    in_sign_position <= '0;
    in_signed_mode   <= 1'b0;
    in_byte_count    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_beats[i]) begin
      send_beat(directed_beats[i]);
      idle_sender(pick_gap(IDLE_MIXED));
    end
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        gap_mode = ($urandom_range(0, 2) == 0) ? IDLE_NONE : IDLE_MIXED;
      end
      // hold the receiver off and keep offering beats until the pipeline backs up
      if (n == PRESSURE_AT) begin
        hold_request = 1'b1;
      end
      if (n >= PRESSURE_AT && n < PRESSURE_AT + 80) begin
        gap_mode = IDLE_NONE;
      end
      send_beat(random_beat());
      idle_sender(pick_gap(gap_mode));
    end
    in_valid <= 1'b0;
    while (bcd_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
